/* rtl/core/pldist_pkg.sv */
// ----------------------------------------------------------------------------
// pldist_pkg
// Shared types, constants and the sequencer control store for the polyline
// distance-to-end block.
// ----------------------------------------------------------------------------
`default_nettype none

package pldist_pkg;

  // Fixed field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned DistW   = 31;
  localparam logic [DistW-1:0] DistMax = 31'h7FFF_FFFF;

  // Defaults for the top-level parameters
  localparam int unsigned DefMaxPoints = 64;
  localparam int unsigned DefFracBits  = 8;

  // Sequencer step addresses
  localparam int unsigned PcW = 4;
  localparam logic [PcW-1:0] StepLoad  = 4'd0;
  localparam logic [PcW-1:0] StepSetup = 4'd1;
  localparam logic [PcW-1:0] StepFirst = 4'd2;
  localparam logic [PcW-1:0] StepDec   = 4'd3;
  localparam logic [PcW-1:0] StepRead  = 4'd4;
  localparam logic [PcW-1:0] StepDiff  = 4'd5;
  localparam logic [PcW-1:0] StepMulX  = 4'd6;
  localparam logic [PcW-1:0] StepMulY  = 4'd7;
  localparam logic [PcW-1:0] StepRoot  = 4'd8;
  localparam logic [PcW-1:0] StepWait  = 4'd9;
  localparam logic [PcW-1:0] StepAcc   = 4'd10;
  localparam logic [PcW-1:0] StepEmit  = 4'd11;
  localparam logic [PcW-1:0] StepEnd   = 4'd12;

  // Condition that holds the step counter in place
  typedef enum logic [1:0] {
    HoldNone,
    HoldFinal,
    HoldOut,
    HoldRoot
  } hold_e;

  // Branch condition taken once the step completes
  typedef enum logic [1:0] {
    JmpNext,
    JmpAlways,
    JmpIdxZero,
    JmpIdxNz
  } jump_e;

  // One control word
  typedef struct packed {
    hold_e          hold_on;
    jump_e          jump;
    logic [PcW-1:0] target;
    logic           set_idx;
    logic           dec_idx;
    logic           mem_rd;
    logic           load_prev;
    logic           load_diff;
    logic           mul_x;
    logic           mul_y;
    logic           root_go;
    logic           acc_clr;
    logic           acc_add;
    logic           emit;
    logic           clr_path;
  } ucode_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '0;
    w.hold_on = HoldNone;
    w.jump    = JmpNext;
    w.target  = StepLoad;
    case (pc)
      StepLoad: begin
        w.hold_on = HoldFinal;
      end
      StepSetup: begin
        w.set_idx = 1'b1;
        w.mem_rd  = 1'b1;
      end
      StepFirst: begin
        w.hold_on   = HoldOut;
        w.load_prev = 1'b1;
        w.acc_clr   = 1'b1;
        w.emit      = 1'b1;
        w.jump      = JmpIdxZero;
        w.target    = StepEnd;
      end
      StepDec: begin
        w.dec_idx = 1'b1;
      end
      StepRead: begin
        w.mem_rd = 1'b1;
      end
      StepDiff: begin
        w.load_diff = 1'b1;
      end
      StepMulX: begin
        w.mul_x = 1'b1;
      end
      StepMulY: begin
        w.mul_y = 1'b1;
      end
      StepRoot: begin
        w.root_go = 1'b1;
      end
      StepWait: begin
        w.hold_on = HoldRoot;
      end
      StepAcc: begin
        w.acc_add = 1'b1;
      end
      StepEmit: begin
        w.hold_on = HoldOut;
        w.emit    = 1'b1;
        w.jump    = JmpIdxNz;
        w.target  = StepDec;
      end
      StepEnd: begin
        w.clr_path = 1'b1;
        w.jump     = JmpAlways;
        w.target   = StepLoad;
      end
      default: begin
        w.jump   = JmpAlways;
        w.target = StepLoad;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/polyline_distance_to_end_top.sv */
// Points load at one transaction per cycle; a final point starts a run.
// Per run: the last stored point's result is emitted first, then each further
// result follows a difference, two squarings, a bit-serial square root and an add.
// No input is taken in a run; a new path loads only after the run has ended.
// Reset: asynchronous, clears sequencer, counters and output valid; point store
// contents are undefined until written.
// ----------------------------------------------------------------------------
// polyline_distance_to_end_top
// Stores path points, then walks them backwards emitting the saturating
// remaining arc length for each, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_distance_to_end_top #(
  parameter int unsigned MAX_POINTS = pldist_pkg::DefMaxPoints,
  parameter int unsigned FRAC_BITS  = pldist_pkg::DefFracBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [pldist_pkg::CoordW-1:0] x_coord_i,
  input  wire logic signed [pldist_pkg::CoordW-1:0] y_coord_i,
  input  wire logic                             final_point_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [pldist_pkg::IdxOutW-1:0]        point_index_o,
  output logic [pldist_pkg::DistW-1:0]          distance_to_end_o,
  output logic                                  run_end_o,
  output logic                                  dropped_points_o
);

  localparam int unsigned IdxW  = $clog2(MAX_POINTS);
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW    = pldist_pkg::CoordW;
  localparam int unsigned DW    = pldist_pkg::DistW;
  localparam int unsigned RadW  = 34 + 2 * FRAC_BITS;
  localparam int unsigned ResW  = RadW / 2;

  // Sequencer
  logic [pldist_pkg::PcW-1:0] pc_q, pc_d;
  pldist_pkg::ucode_t         uw;
  logic                       hold;
  logic                       take;

  // Path store bookkeeping
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic [IdxW-1:0] idx_q;
  logic            in_acc;

  // Point store
  logic [2*CW-1:0] mem_q [MAX_POINTS];
  logic [2*CW-1:0] rd_q;
  logic [IdxW-1:0] rd_addr;

  // Segment datapath
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ux_q, uy_q;
  logic [CW-1:0]        mul_a;
  logic [2*CW-1:0]      prod;
  logic [2*CW-1:0]      sqx_q, sqy_q;
  logic [2*CW:0]        sq_sum;
  logic [RadW-1:0]      rad;
  logic                 root_busy;
  logic [ResW-1:0]      root;
  logic [DW-1:0]        acc_q;
  logic [DW:0]          acc_sum;

  // Output register
  logic                      out_valid_q;
  logic [pldist_pkg::IdxOutW-1:0] idx_out_q;
  logic [DW-1:0]             dist_q;
  logic                      run_end_q;
  logic                      drop_q;
  logic                      out_space;
  logic                      emit_go;

  // Decode the current step
  assign uw        = pldist_pkg::ucode_rom(pc_q);
  assign in_stall_o = (pc_q != pldist_pkg::StepLoad);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_space = !out_valid_q || !out_stall_i;

  always_comb begin
    case (uw.hold_on)
      pldist_pkg::HoldFinal: hold = !(in_acc && final_point_i);
      pldist_pkg::HoldOut:   hold = !out_space;
      pldist_pkg::HoldRoot:  hold = root_busy;
      default:               hold = 1'b0;
    endcase
    case (uw.jump)
      pldist_pkg::JmpAlways:  take = 1'b1;
      pldist_pkg::JmpIdxZero: take = (idx_q == '0);
      pldist_pkg::JmpIdxNz:   take = (idx_q != '0);
      default:                take = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  assign emit_go = uw.emit && out_space;

  // Advance the step counter, track the path and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pldist_pkg::StepLoad;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (uw.clr_path) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (in_acc) begin
        if (cnt_q < CntW'(MAX_POINTS)) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write incoming points while there is room
  always_ff @(posedge clk_i) begin
    if (in_acc && (cnt_q < CntW'(MAX_POINTS))) begin
      mem_q[cnt_q[IdxW-1:0]] <= {x_coord_i, y_coord_i};
    end
  end

  // Read the store, registered
  assign rd_addr = uw.set_idx ? IdxW'(cnt_q - 1'b1) : idx_q;

  always_ff @(posedge clk_i) begin
    if (uw.mem_rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Segment differences and magnitudes
  always_comb begin
    dx = (CW+1)'(prev_x_q) - (CW+1)'($signed(rd_q[2*CW-1:CW]));
    dy = (CW+1)'(prev_y_q) - (CW+1)'($signed(rd_q[CW-1:0]));
  end

  // Shared squaring multiplier
  assign mul_a  = uw.mul_y ? uy_q : ux_q;
  assign prod   = mul_a * mul_a;
  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rad    = RadW'(sq_sum) << (2 * FRAC_BITS);

  pldist_isqrt #(
    .RAD_W (RadW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (uw.root_go),
    .rad_i   (rad),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  // Saturating accumulate
  assign acc_sum = {1'b0, acc_q} + (DW+1)'(root);

  // Datapath registers driven by the control word
  always_ff @(posedge clk_i) begin
    if (uw.set_idx) begin
      idx_q <= IdxW'(cnt_q - 1'b1);
    end else if (uw.dec_idx) begin
      idx_q <= idx_q - 1'b1;
    end
    if (uw.load_prev || uw.load_diff) begin
      prev_x_q <= $signed(rd_q[2*CW-1:CW]);
      prev_y_q <= $signed(rd_q[CW-1:0]);
    end
    if (uw.load_diff) begin
      ux_q <= dx[CW] ? CW'(-dx) : CW'(dx);
      uy_q <= dy[CW] ? CW'(-dy) : CW'(dy);
    end
    if (uw.mul_x) begin
      sqx_q <= prod;
    end
    if (uw.mul_y) begin
      sqy_q <= prod;
    end
    if (uw.acc_clr) begin
      acc_q <= '0;
    end else if (uw.acc_add) begin
      acc_q <= acc_sum[DW] ? pldist_pkg::DistMax : acc_sum[DW-1:0];
    end
  end

  // Hold the result transaction until it is taken
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      idx_out_q <= pldist_pkg::IdxOutW'(idx_q);
      dist_q    <= uw.acc_clr ? '0 : acc_q;
      run_end_q <= (idx_q == '0);
      drop_q    <= ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign point_index_o     = idx_out_q;
  assign distance_to_end_o = dist_q;
  assign run_end_o         = run_end_q;
  assign dropped_points_o  = drop_q;

endmodule

`default_nettype wire

/* rtl/core/pldist_isqrt.sv */
// ----------------------------------------------------------------------------
// pldist_isqrt
// Bit-serial integer square root: one result bit per cycle, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module pldist_isqrt #(
  parameter int unsigned RAD_W = 50
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  output logic                      busy_o,
  output logic [RAD_W/2-1:0]        root_o
);

  localparam int unsigned ResW = RAD_W / 2;
  localparam int unsigned RemW = ResW + 2;
  localparam int unsigned ItW  = $clog2(ResW + 1);

  logic [RAD_W-1:0] rad_q;
  logic [RemW-1:0]  rem_q;
  logic [ResW-1:0]  root_q;
  logic [ItW-1:0]   it_q;
  logic             busy_q;

  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;
  logic             fits;

  // Bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q[ResW-1:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control: iteration count and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      it_q   <= ItW'(ResW);
    end else if (busy_q) begin
      it_q   <= it_q - 1'b1;
      busy_q <= (it_q != ItW'(1));
    end
  end

  // Datapath: remainder, partial root and radicand shifter
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ResW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/core/pldist_checker.sv */
// ----------------------------------------------------------------------------
// pldist_checker
// Port-level checks for the polyline distance-to-end block.
// ----------------------------------------------------------------------------
`default_nettype none

module pldist_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [pldist_pkg::CoordW-1:0]     x_coord_i,
  input wire logic [pldist_pkg::CoordW-1:0]     y_coord_i,
  input wire logic                              final_point_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [pldist_pkg::IdxOutW-1:0]    point_index_o,
  input wire logic [pldist_pkg::DistW-1:0]      distance_to_end_o,
  input wire logic                              run_end_o,
  input wire logic                              dropped_points_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_index_o)
      && $stable(distance_to_end_o) && $stable(run_end_o) && $stable(dropped_points_o))
    else $error("result changed while stalled");

  // The run ends exactly on point zero
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_end_o == (point_index_o == '0)))
    else $error("run_end does not match point index zero");

  // A final point starts a run, so input is stalled next
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && final_point_i |=> in_stall_o)
    else $error("input taken right after a final point");

  // A plain point keeps the block loading
  a_keep_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !final_point_i |=> !in_stall_o)
    else $error("input stalled while loading a path");

endmodule

bind polyline_distance_to_end_top pldist_checker u_pldist_checker (.*);

`default_nettype wire
